[hw/rtl/ccs_pkg.sv]
// Shared types, constants and helpers of the column change statistics block.
`default_nettype none

package ccs_pkg;

    localparam int CNT_W    = 32;
    localparam int DIST_W   = 9;
    localparam int VAL_W    = 8;
    localparam int SLOT_W   = 6;
    localparam int VALUES   = 256;
    localparam int IN_W     = 16;
    localparam int OUT_W    = 80;
    localparam int OUT_USED = CNT_W + DIST_W + CNT_W;

    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
    localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(VALUES);

    // Per-slot record kept in the slot table
    typedef struct packed {
        logic              valid;
        logic [VAL_W-1:0]  last_value;
        logic [CNT_W-1:0]  change_count;
        logic [DIST_W-1:0] distinct_count;
    } slot_entry_t;

    // Clear sweep control toward the memories
    typedef struct packed {
        logic busy;
        logic slot_wr;
    } clr_ctl_t;

    // Saturating increment of a 32-bit counter
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
        logic [CNT_W-1:0] r;
        r = (x == CNT_MAX) ? x : x + CNT_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/column_change_statistics_top.sv]
// Top level of the column change statistics block: pipeline, forwarding, row count.
// Path: read at the accepting edge, update in the p1 stage, output from out_valid_reg.
// Throughput: one item per cycle unless stalled or sweeping; the read-modify-write of the
//   slot table and seen map closes through a one-entry forwarding register.
// Reset: rst_n clears control at once, then a sweep over every slot and byte value
//   clears the seen map and slot table; s_axis_tready stays low until it ends.
`default_nettype none

module column_change_statistics_top #(
    parameter int SLOTS = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // [5:0] slot, [13:6] value, [15:14] zero
    input  wire logic [ccs_pkg::IN_W-1:0]  s_axis_tdata,
    // row_end
    input  wire logic                      s_axis_tlast,
    output logic                           m_axis_tvalid,
    input  wire logic                      m_axis_tready,
    // [31:0] change_total, [40:32] distinct_total, [72:41] row_total, [79:73] zero
    output logic [ccs_pkg::OUT_W-1:0]      m_axis_tdata
);
    import ccs_pkg::*;

    localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SEEN_W = SIDX_W + VAL_W;

    // Input field split
    logic [SLOT_W-1:0] in_slot;
    logic [VAL_W-1:0]  in_value;
    logic              in_range;
    logic [SIDX_W-1:0] in_sidx;
    logic              accept;
    logic              adv;

    // Clear sweep
    clr_ctl_t          clr_ctl;
    logic [SIDX_W-1:0] clr_slot;
    logic [VAL_W-1:0]  clr_value;

    // Update stage registers
    logic              p1_valid_reg;
    logic [SIDX_W-1:0] p1_sidx_reg;
    logic [VAL_W-1:0]  p1_value_reg;
    logic              p1_end_reg;
    logic              p1_range_reg;

    // Forwarding of the last written record
    logic              fwd_valid_reg;
    logic [SIDX_W-1:0] fwd_sidx_reg;
    slot_entry_t       fwd_entry_reg;

    logic [CNT_W-1:0]  row_reg;
    logic              out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;

    // Memory ports
    slot_entry_t       slot_rd;
    slot_entry_t       slot_wdata;
    logic              slot_wen;
    logic [SIDX_W-1:0] slot_waddr;
    logic              seen_rd;
    logic              seen_wen;
    logic [SEEN_W-1:0] seen_waddr;
    logic              seen_wbit;

    // Update logic
    logic              fwd_hit;
    slot_entry_t       cur;
    logic              seen_cur;
    logic              changed;
    logic              item_wr;
    slot_entry_t       new_entry;
    logic [CNT_W-1:0]  chg_res;
    logic [DIST_W-1:0] dst_res;
    logic [CNT_W-1:0]  row_next;

    assign in_slot  = s_axis_tdata[SLOT_W-1:0];
    assign in_value = s_axis_tdata[SLOT_W+VAL_W-1:SLOT_W];
    assign in_range = (int'(in_slot) < SLOTS);
    assign in_sidx  = in_range ? SIDX_W'(in_slot) : '0;

    // The output register frees when empty or taken
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !clr_ctl.busy && adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ccs_clear_seq #(
        .SLOTS  (SLOTS),
        .SIDX_W (SIDX_W)
    ) u_clear (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (clr_ctl),
        .clr_slot  (clr_slot),
        .clr_value (clr_value)
    );

    ccs_slot_table #(
        .SLOTS  (SLOTS),
        .SIDX_W (SIDX_W)
    ) u_slot_table (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (in_sidx),
        .rd_data (slot_rd),
        .wr_en   (slot_wen),
        .wr_addr (slot_waddr),
        .wr_data (slot_wdata)
    );

    ccs_seen_map #(
        .SLOTS  (SLOTS),
        .SIDX_W (SIDX_W)
    ) u_seen_map (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr ({in_sidx, in_value}),
        .rd_bit  (seen_rd),
        .wr_en   (seen_wen),
        .wr_addr (seen_waddr),
        .wr_bit  (seen_wbit)
    );

    // Merge forwarded record, decide change, build new record and result
    always_comb
    begin
        fwd_hit  = fwd_valid_reg && (fwd_sidx_reg == p1_sidx_reg);
        cur      = fwd_hit ? fwd_entry_reg : slot_rd;
        seen_cur = seen_rd || (fwd_hit && (fwd_entry_reg.last_value == p1_value_reg));
        changed  = !cur.valid || (cur.last_value != p1_value_reg);
        item_wr  = p1_valid_reg && p1_range_reg && changed && adv;

        new_entry                = cur;
        new_entry.valid          = 1'b1;
        new_entry.last_value     = p1_value_reg;
        new_entry.change_count   = sat_inc(cur.change_count);
        if (!seen_cur && (cur.distinct_count < DIST_MAX))
        begin
            new_entry.distinct_count = cur.distinct_count + DIST_W'(1);
        end

        chg_res = '0;
        dst_res = '0;
        if (p1_range_reg)
        begin
            chg_res = changed ? new_entry.change_count : cur.change_count;
            dst_res = changed ? new_entry.distinct_count : cur.distinct_count;
        end

        row_next = p1_end_reg ? sat_inc(row_reg) : row_reg;
    end

    // Route memory writes from the sweep or the update stage
    always_comb
    begin
        if (clr_ctl.busy)
        begin
            slot_wen   = clr_ctl.slot_wr;
            slot_waddr = clr_slot;
            slot_wdata = '0;
            seen_wen   = 1'b1;
            seen_waddr = {clr_slot, clr_value};
            seen_wbit  = 1'b0;
        end
        else
        begin
            slot_wen   = item_wr;
            slot_waddr = p1_sidx_reg;
            slot_wdata = new_entry;
            seen_wen   = item_wr;
            seen_waddr = {p1_sidx_reg, p1_value_reg};
            seen_wbit  = 1'b1;
        end
    end

    // Advance the pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            row_reg       <= '0;
        end
        else if (adv)
        begin
            p1_valid_reg  <= accept;
            fwd_valid_reg <= item_wr;
            out_valid_reg <= p1_valid_reg;
            if (p1_valid_reg)
            begin
                row_reg <= row_next;
            end
        end
    end

    // Hold payload while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_sidx_reg  <= in_sidx;
            p1_value_reg <= in_value;
            p1_end_reg   <= s_axis_tlast;
            p1_range_reg <= in_range;
        end
        if (adv)
        begin
            fwd_sidx_reg  <= p1_sidx_reg;
            fwd_entry_reg <= new_entry;
            if (p1_valid_reg)
            begin
                out_data_reg <= {(OUT_W-OUT_USED)'(0), row_next, dst_res, chg_res};
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

[hw/rtl/ccs_clear_seq.sv]
// Post-reset sweep that clears the seen map and the slot table.
`default_nettype none

module ccs_clear_seq #(
    parameter int SLOTS  = 64,
    parameter int SIDX_W = 6
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    output ccs_pkg::clr_ctl_t      ctl,
    output logic [SIDX_W-1:0]      clr_slot,
    output logic [ccs_pkg::VAL_W-1:0] clr_value
);
    import ccs_pkg::*;

    localparam logic [SIDX_W-1:0] LAST_SLOT = SIDX_W'(SLOTS - 1);

    logic              busy_reg;
    logic [SIDX_W-1:0] slot_reg;
    logic [VAL_W-1:0]  value_reg;

    // Walk every slot and every byte value once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            slot_reg  <= '0;
            value_reg <= '0;
        end
        else if (busy_reg)
        begin
            value_reg <= value_reg + VAL_W'(1);
            if (value_reg == '1)
            begin
                if (slot_reg == LAST_SLOT)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    slot_reg <= slot_reg + SIDX_W'(1);
                end
            end
        end
    end

    assign ctl.busy    = busy_reg;
    assign ctl.slot_wr = busy_reg && (value_reg == '0);
    assign clr_slot    = slot_reg;
    assign clr_value   = value_reg;

endmodule

`default_nettype wire

[hw/rtl/ccs_slot_table.sv]
// Per-slot record memory: one write port, one registered read port.
`default_nettype none

module ccs_slot_table #(
    parameter int SLOTS  = 64,
    parameter int SIDX_W = 6
) (
    input  wire logic                 clk,
    input  wire logic                 rd_en,
    input  wire logic [SIDX_W-1:0]    rd_addr,
    output ccs_pkg::slot_entry_t      rd_data,
    input  wire logic                 wr_en,
    input  wire logic [SIDX_W-1:0]    wr_addr,
    input  ccs_pkg::slot_entry_t      wr_data
);
    import ccs_pkg::*;

    slot_entry_t mem [SLOTS];
    slot_entry_t rd_data_reg;

    // Write first in code order; the read still returns the old entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hw/rtl/ccs_seen_map.sv]
// Seen-value bit map, one bit per slot and byte value, registered read.
`default_nettype none

module ccs_seen_map #(
    parameter int SLOTS  = 64,
    parameter int SIDX_W = 6
) (
    input  wire logic                          clk,
    input  wire logic                          rd_en,
    input  wire logic [SIDX_W+ccs_pkg::VAL_W-1:0] rd_addr,
    output logic                               rd_bit,
    input  wire logic                          wr_en,
    input  wire logic [SIDX_W+ccs_pkg::VAL_W-1:0] wr_addr,
    input  wire logic                          wr_bit
);
    import ccs_pkg::*;

    logic mem [SLOTS*VALUES];
    logic rd_bit_reg;

    // Single bit store with one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_bit;
        end
        if (rd_en)
        begin
            rd_bit_reg <= mem[rd_addr];
        end
    end

    assign rd_bit = rd_bit_reg;

endmodule

`default_nettype wire

[hw/rtl/ccs_checker.sv]
// Port-level checks of the column change statistics block, bound to the top level.
`default_nettype none

module ccs_checker (
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      s_axis_tready,
    input wire logic                      m_axis_tvalid,
    input wire logic                      m_axis_tready,
    input wire logic [ccs_pkg::OUT_W-1:0] m_axis_tdata
);
    import ccs_pkg::*;

    logic [CNT_W-1:0]  chg;
    logic [DIST_W-1:0] dst;
    logic [CNT_W-1:0]  rows;

    assign chg  = m_axis_tdata[CNT_W-1:0];
    assign dst  = m_axis_tdata[CNT_W+DIST_W-1:CNT_W];
    assign rows = m_axis_tdata[OUT_USED-1:CNT_W+DIST_W];

    // A stalled item holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // Distinct count never passes 256 nor the change count
    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (dst <= DIST_MAX) && (32'(dst) <= chg))
        else $error("distinct count out of bounds");

    // Row count never falls between consecutive results
    a_row_mono: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |=> !m_axis_tvalid || (rows >= $past(rows)))
        else $error("row count decreased");

    // A full, stalled output register blocks input
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted with output stalled");

endmodule

bind column_change_statistics_top ccs_checker u_ccs_checker (.*);

`default_nettype wire

[verif/column_change_statistics_top_tb.sv]
// Self-checking testbench of the column change statistics block.
`default_nettype none

module column_change_statistics_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ccs_pkg::*;

    localparam int NUM_SLOTS   = 64;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 8;

    // One result item as the block reports it
    typedef struct packed {
        logic [CNT_W-1:0]  change_total;
        logic [DIST_W-1:0] distinct_total;
        logic [CNT_W-1:0]  row_total;
    } col_stats_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;

    // Shadow copy of the per-slot column state
    logic              prev_ok    [NUM_SLOTS];
    logic [VAL_W-1:0]  prev_byte  [NUM_SLOTS];
    logic [VALUES-1:0] seen_bits  [NUM_SLOTS];
    logic [CNT_W-1:0]  chg_cnt    [NUM_SLOTS];
    logic [DIST_W-1:0] dist_cnt   [NUM_SLOTS];
    logic [CNT_W-1:0]  rows_done;

    col_stats_t        stats_due[$];
    int                fails = 0;
    int                cycles = 0;
    logic              idle_on = 1'b1;
    int                hold_len = 0;
    int                hold_req_id = 0;
    int                hold_seen_id = 0;
    int                hold_left = 0;

    column_change_statistics_top #(
        .SLOTS (NUM_SLOTS)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Free-running clock, 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Clear the shadow state to its reset values
    initial
    begin
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            prev_ok[k]   = 1'b0;
            prev_byte[k] = '0;
            seen_bits[k] = '0;
            chg_cnt[k]   = '0;
            dist_cnt[k]  = '0;
        end
        rows_done = '0;
    end

    // Update the shadow state with one byte and return the stats it yields
    function automatic col_stats_t profile_byte(input logic [SLOT_W-1:0] slot,
                                                input logic [VAL_W-1:0] value,
                                                input logic row_end);
        col_stats_t r;
        int k;
        k = int'(slot);
        r = '0;
        if (row_end && rows_done != CNT_MAX)
            rows_done = rows_done + 1'b1;
        if (k < NUM_SLOTS)
        begin
            if (!prev_ok[k] || prev_byte[k] != value)
            begin
                prev_ok[k]   = 1'b1;
                prev_byte[k] = value;
                if (chg_cnt[k] != CNT_MAX)
                    chg_cnt[k] = chg_cnt[k] + 1'b1;
                if (!seen_bits[k][value])
                begin
                    seen_bits[k][value] = 1'b1;
                    if (dist_cnt[k] < DIST_MAX)
                        dist_cnt[k] = dist_cnt[k] + 1'b1;
                end
            end
            r.change_total   = chg_cnt[k];
            r.distinct_total = dist_cnt[k];
        end
        r.row_total = rows_done;
        return r;
    endfunction

    // Offer one item after an optional idle gap, hold it until accepted, then queue its expected stats
    task automatic offer_byte(input logic [SLOT_W-1:0] slot, input logic [VAL_W-1:0] value,
                              input logic row_end);
        int gap;
        if (idle_on && $urandom_range(0, 99) < 9)
        begin
            gap = $urandom_range(1, 4);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = IN_W'({value, slot});
        s_axis_tlast  = row_end;
        @(posedge clk);
        while (!(s_axis_tready && rst_n))
            @(posedge clk);
        stats_due.push_back(profile_byte(slot, value, row_end));
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;
        while (stats_due.size() != 0)
            @(negedge clk);
    endtask

    // Receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req_id != hold_seen_id)
        begin
            hold_seen_id = hold_req_id;
            hold_left    = hold_len;
        end
        if (hold_left > 0)
        begin
            hold_left     = hold_left - 1;
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = !(idle_on && $urandom_range(0, 99) < 9);
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        col_stats_t got;
        col_stats_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.change_total   = m_axis_tdata[CNT_W-1:0];
            got.distinct_total = m_axis_tdata[CNT_W +: DIST_W];
            got.row_total      = m_axis_tdata[CNT_W+DIST_W +: CNT_W];
            if (stats_due.size() == 0)
            begin
                $error("unexpected result item: change_total %0d distinct_total %0d row_total %0d",
                       got.change_total, got.distinct_total, got.row_total);
                fails++;
            end
            else
            begin
                want = stats_due.pop_front();
                if (got.change_total !== want.change_total)
                begin
                    $error("change_total: expected %0d, got %0d",
                           want.change_total, got.change_total);
                    fails++;
                end
                if (got.distinct_total !== want.distinct_total)
                begin
                    $error("distinct_total: expected %0d, got %0d",
                           want.distinct_total, got.distinct_total);
                    fails++;
                end
                if (got.row_total !== want.row_total)
                begin
                    $error("row_total: expected %0d, got %0d", want.row_total, got.row_total);
                    fails++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Field extremes, first byte, repeats and same-slot runs back to back
    task automatic test_directed();
        offer_byte(6'd0, 8'h00, 1'b0);
        offer_byte(6'd0, 8'h00, 1'b0);
        offer_byte(6'd0, 8'hFF, 1'b0);
        offer_byte(6'd0, 8'h00, 1'b1);
        offer_byte(6'd63, 8'hFF, 1'b1);
        offer_byte(6'd63, 8'hFF, 1'b1);
        offer_byte(6'd21, 8'hAA, 1'b0);
        offer_byte(6'd42, 8'h55, 1'b0);
        offer_byte(6'd21, 8'h55, 1'b0);
        offer_byte(6'd42, 8'hAA, 1'b1);
        offer_byte(6'd5, 8'h01, 1'b0);
        offer_byte(6'd5, 8'h02, 1'b0);
        offer_byte(6'd5, 8'h01, 1'b0);
        offer_byte(6'd5, 8'h01, 1'b0);
        offer_byte(6'd5, 8'h03, 1'b1);
        offer_byte(6'd6, 8'h09, 1'b0);
        offer_byte(6'd7, 8'h09, 1'b0);
        offer_byte(6'd6, 8'h09, 1'b0);
        offer_byte(6'd7, 8'h08, 1'b1);
        offer_byte(6'd32, 8'h80, 1'b0);
        offer_byte(6'd16, 8'h7F, 1'b1);
    endtask

    // Walk one slot through every byte value so its distinct count tops out
    task automatic test_distinct_limit();
        logic [VAL_W-1:0] order [VALUES];
        logic [VAL_W-1:0] tmp;
        logic [SLOT_W-1:0] slot;
        int j;
        slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
        for (int i = 0; i < VALUES; i++)
            order[i] = VAL_W'(i);
        for (int i = VALUES - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int i = 0; i < VALUES; i++)
            offer_byte(slot, order[i], ($urandom_range(0, 15) == 0));
        // revisit known values: changes go on, distinct holds
        for (int i = 0; i < 16; i++)
            offer_byte(slot, VAL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Rows of a fixed column layout with repetitive content, some noise
    task automatic test_row_stream(input int n_items);
        logic [VAL_W-1:0] col_prev [NUM_SLOTS];
        logic [VAL_W-1:0] v;
        int sent;
        int width;
        int base;
        int rows;
        int pick;
        sent = 0;
        for (int k = 0; k < NUM_SLOTS; k++)
            col_prev[k] = VAL_W'($urandom_range(0, 255));
        while (sent < n_items)
        begin
            width = ($urandom_range(0, 7) == 0) ? $urandom_range(17, NUM_SLOTS)
                                                : $urandom_range(1, 16);
            base  = $urandom_range(0, NUM_SLOTS - width);
            rows  = $urandom_range(2, 8);
            for (int r = 0; r < rows && sent < n_items; r++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise byte outside the row structure
                    offer_byte(SLOT_W'($urandom_range(0, 63)), VAL_W'($urandom_range(0, 255)),
                               1'($urandom_range(0, 1)));
                    sent++;
                end
                for (int c = 0; c < width; c++)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6)
                        v = col_prev[base + c];
                    else if (pick < 9)
                        v = VAL_W'($urandom_range(0, 7));
                    else
                        v = VAL_W'($urandom_range(0, 255));
                    col_prev[base + c] = v;
                    // an occasional broken row loses or gains its end mark
                    offer_byte(SLOT_W'(base + c), v,
                               (c == width - 1) ^ ($urandom_range(0, 39) == 0));
                    sent++;
                end
            end
        end
    endtask

    // Fully random bytes, with runs on one slot to stress forwarding
    task automatic test_random_bytes(input int n_items);
        logic [SLOT_W-1:0] slot;
        int run;
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
            run  = $urandom_range(1, 4);
            for (int i = 0; i < run && sent < n_items; i++)
            begin
                offer_byte(slot, VAL_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                             : $urandom_range(0, 255)),
                           ($urandom_range(0, 3) == 0));
                sent++;
            end
        end
    endtask

    // Receiver holds off long while the sender keeps offering
    task automatic test_output_hold();
        hold_len = 400;
        hold_req_id++;
        test_random_bytes(80);
    endtask

    // Sender pauses until all results are back, then resumes
    task automatic test_drain_pause();
        test_random_bytes(60);
        drain_results();
        test_row_stream(60);
    endtask

    // Long stretch with no idling on either side
    task automatic test_no_idle();
        idle_on = 1'b0;
        test_random_bytes(150);
        test_row_stream(150);
        idle_on = 1'b1;
    endtask

    // Reset, run the tests in turn, then report
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b1;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_distinct_limit();
        test_row_stream(600);
        test_output_hold();
        test_drain_pause();
        test_no_idle();
        test_random_bytes(300);

        drain_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fails == 0 && stats_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
